// ===== design/sed_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the string escape decoder.
// No dependencies; imported by string_escape_decoder.
package sed_pkg;

    localparam int POS_OUT_W = 16;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [1:0] ERR_BAD_BYTE   = 2'd0;
    localparam logic [1:0] ERR_BAD_ESCAPE = 2'd1;
    localparam logic [1:0] ERR_END_OF_DATA = 2'd2;

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    localparam logic [7:0] DELIM_RESET = 8'd34;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] LETTER_COUNT = 8'd26;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           value;
        logic [1:0]           error_code;
        logic [POS_OUT_W-1:0] position;
        logic                 last;
    } result_t;

    // Radix and digit limit of each numeric escape form.
    function automatic logic [4:0] radix_of(input logic [1:0] sel);
        logic [4:0] r;
        case (sel)
            RADIX_DEC: r = 5'd10;
            RADIX_OCT: r = 5'd8;
            RADIX_HEX: r = 5'd16;
            default:   r = 5'd2;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] limit_of(input logic [1:0] sel);
        logic [2:0] l;
        case (sel)
            RADIX_DEC: l = 3'd3;
            RADIX_OCT: l = 3'd3;
            RADIX_HEX: l = 3'd2;
            default:   l = 3'd7;
        endcase
        return l;
    endfunction

    // Returns {valid, digit}; letters of either case count from ten.
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        logic       ok;
        ok = 1'b1;
        if (c >= CH_ZERO && c < CH_ZERO + 8'd10) begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_UPPER_A && c < CH_UPPER_A + LETTER_COUNT) begin
            d = c - CH_UPPER_A + 8'd10;
        end
        else if (c >= CH_LOWER_A && c < CH_LOWER_A + LETTER_COUNT) begin
            d = c - CH_LOWER_A + 8'd10;
        end
        else begin
            d  = 8'd0;
            ok = 1'b0;
        end
        return {ok, d[5:0]};
    endfunction

endpackage

// ===== design/string_escape_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the string escape decoder: decode logic and result queue.
// Depends on sed_pkg.
//
// Usage
//   Input channel (in_valid/in_ready) carries one raw byte per transfer with
//   start_req and no_more flags. Output channel (out_valid/out_ready) carries
//   one result per transfer; an input byte yields zero, one or two results,
//   and last marks the final one of each byte.
//   The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
//   delimiter byte and is always ready; write it only while the block is idle.
//   Results are registered in the queue before the output. Bytes are
//   decoded combinationally, so an input transfer can be taken every cycle
//   while in_ready is high; the output port sets the sustained rate, one result
//   per cycle while out_ready is high, so two results take two transfers.
//   Results wait in a three-entry queue; input is accepted while it holds at
//   most one result, so a stalled receiver holds off the sender after that.
//   Reset empties the queue, puts the decoder in the idle state (no results
//   until a byte with start_req) and sets the delimiter to the double quote.
module string_escape_decoder #(
    parameter int POS_WIDTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [7:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         start_req,
    input  logic                         no_more,
    input  logic [7:0]                   byte_req,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   kind,
    output logic [7:0]                   value,
    output logic [1:0]                   error_code,
    output logic [sed_pkg::POS_OUT_W-1:0] position,
    output logic                         last
);
    import sed_pkg::*;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_BODY = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_NUM  = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;
    localparam logic [2:0] PH_FAIL = 3'd5;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    logic [7:0]           delim_reg;
    logic [2:0]           phase_reg,  phase_next;
    logic [1:0]           radix_reg,  radix_next;
    logic [2:0]           cnt_reg,    cnt_next;
    logic [9:0]           acc_reg,    acc_next;
    logic [POS_WIDTH-1:0] esc_pos_reg, esc_pos_next;
    logic [POS_WIDTH-1:0] byte_pos_reg, byte_pos_next;

    result_t              q_reg [3];
    result_t              q_next [3];
    logic [1:0]           q_cnt_reg, q_cnt_next;

    logic                 push;
    logic                 pop;
    logic [1:0]           base;
    result_t              res0, res1;
    logic [1:0]           res_n;

    function automatic logic [POS_WIDTH-1:0] pos_inc(input logic [POS_WIDTH-1:0] p);
        return (p == POS_MAX) ? p : p + 1'b1;
    endfunction

    function automatic result_t make_res(input logic [1:0] k, input logic [7:0] v,
                                         input logic [1:0] code,
                                         input logic [POS_WIDTH-1:0] p);
        result_t r;
        r.kind       = k;
        r.value      = v;
        r.error_code = code;
        r.position   = POS_OUT_W'(p);
        r.last       = 1'b0;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (q_cnt_reg <= 2'd1);
    assign out_valid = (q_cnt_reg != 2'd0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    assign kind       = q_reg[0].kind;
    assign value      = q_reg[0].value;
    assign error_code = q_reg[0].error_code;
    assign position   = q_reg[0].position;
    assign last       = q_reg[0].last;

    // Decode of one byte against the current state.
    always_comb
    begin
        logic [2:0]           ph;
        logic [1:0]           rsel;
        logic [2:0]           cnt;
        logic [9:0]           acc;
        logic [POS_WIDTH-1:0] esp;
        logic [POS_WIDTH-1:0] bpos;
        logic [6:0]           dig;
        logic                 d_ok;
        logic [4:0]           radix;
        logic [14:0]          prod;
        logic [9:0]           acc_new;
        logic [2:0]           cnt_new;
        logic                 body_has;
        result_t              body_res;
        logic [2:0]           body_phase;
        logic [7:0]           esc_val;
        logic                 esc_simple;

        ph   = start_req ? PH_BODY : phase_reg;
        rsel = start_req ? RADIX_DEC : radix_reg;
        cnt  = start_req ? 3'd0 : cnt_reg;
        acc  = start_req ? 10'd0 : acc_reg;
        esp  = start_req ? '0 : esc_pos_reg;
        bpos = start_req ? '0 : byte_pos_reg;

        dig     = digit_of(byte_req);
        radix   = radix_of(rsel);
        d_ok    = dig[6] && ({1'b0, dig[5:0]} < {2'b00, radix});
        prod    = {5'd0, acc} * {10'd0, radix};
        acc_new = 10'(prod[9:0] + {4'd0, dig[5:0]});
        cnt_new = cnt + 3'd1;

        // Handling of a byte in the string body.
        body_has   = 1'b1;
        body_res   = make_res(KIND_BYTE, byte_req, ERR_BAD_BYTE, '0);
        body_phase = PH_BODY;
        if (byte_req == delim_reg) begin
            body_res   = make_res(KIND_DONE, 8'd0, ERR_BAD_BYTE, bpos);
            body_phase = PH_DONE;
        end
        else if (byte_req == CH_BACKSLASH) begin
            body_has   = 1'b0;
            body_phase = PH_ESC;
        end
        else if (!(byte_req >= CH_SPACE && byte_req <= CH_DEL)) begin
            body_res   = make_res(KIND_ERROR, 8'd0, ERR_BAD_BYTE, bpos);
            body_phase = PH_FAIL;
        end

        esc_simple = 1'b1;
        case (byte_req)
            8'h61:   esc_val = 8'd7;
            8'h62:   esc_val = 8'd8;
            8'h66:   esc_val = 8'd12;
            8'h6E:   esc_val = 8'd10;
            8'h72:   esc_val = 8'd13;
            8'h74:   esc_val = 8'd9;
            8'h76:   esc_val = 8'd11;
            8'h5C, 8'h27, 8'h22, 8'h60: esc_val = byte_req;
            default:
            begin
                esc_val    = 8'd0;
                esc_simple = 1'b0;
            end
        endcase

        phase_next    = ph;
        radix_next    = rsel;
        cnt_next      = cnt;
        acc_next      = acc;
        esc_pos_next  = esp;
        byte_pos_next = (no_more) ? bpos : pos_inc(bpos);
        res0  = make_res(KIND_BYTE, 8'd0, ERR_BAD_BYTE, '0);
        res1  = res0;
        res_n = 2'd0;

        if (!(ph == PH_BODY || ph == PH_ESC || ph == PH_NUM)) begin
            byte_pos_next = bpos;
        end
        else if (no_more) begin
            phase_next = PH_FAIL;
            res_n      = 2'd1;
            if (ph == PH_NUM && (cnt == 3'd0 || acc[9:8] != 2'b00)) begin
                res0 = make_res(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE, esp);
            end
            else if (ph == PH_NUM) begin
                res0  = make_res(KIND_BYTE, acc[7:0], ERR_BAD_BYTE, '0);
                res1  = make_res(KIND_ERROR, 8'd0, ERR_END_OF_DATA, bpos);
                res_n = 2'd2;
            end
            else begin
                res0 = make_res(KIND_ERROR, 8'd0, ERR_END_OF_DATA, bpos);
            end
        end
        else if (ph == PH_BODY) begin
            phase_next = body_phase;
            res0       = body_res;
            res_n      = {1'b0, body_has};
        end
        else if (ph == PH_ESC) begin
            if (esc_simple) begin
                phase_next = PH_BODY;
                res0       = make_res(KIND_BYTE, esc_val, ERR_BAD_BYTE, '0);
                res_n      = 2'd1;
            end
            else if (byte_req == 8'h6F || byte_req == 8'h78 || byte_req == 8'h42) begin
                phase_next   = PH_NUM;
                radix_next   = (byte_req == 8'h6F) ? RADIX_OCT :
                               (byte_req == 8'h78) ? RADIX_HEX : RADIX_BIN;
                acc_next     = 10'd0;
                cnt_next     = 3'd0;
                esc_pos_next = pos_inc(bpos);
            end
            else if (dig[6] && dig[5:0] < 6'd10) begin
                phase_next   = PH_NUM;
                radix_next   = RADIX_DEC;
                acc_next     = {4'd0, dig[5:0]};
                cnt_next     = 3'd1;
                esc_pos_next = bpos;
            end
            else begin
                phase_next = PH_FAIL;
                res0       = make_res(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE, bpos);
                res_n      = 2'd1;
            end
        end
        else begin
            // Numeric escape in progress.
            if (d_ok) begin
                acc_next = acc_new;
                cnt_next = cnt_new;
                if (cnt_new >= limit_of(rsel)) begin
                    res_n = 2'd1;
                    if (acc_new[9:8] != 2'b00) begin
                        phase_next = PH_FAIL;
                        res0 = make_res(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE, esp);
                    end
                    else begin
                        phase_next = PH_BODY;
                        res0 = make_res(KIND_BYTE, acc_new[7:0], ERR_BAD_BYTE, '0);
                    end
                end
            end
            else if (cnt == 3'd0 || acc[9:8] != 2'b00) begin
                phase_next = PH_FAIL;
                res0       = make_res(KIND_ERROR, 8'd0, ERR_BAD_ESCAPE, esp);
                res_n      = 2'd1;
            end
            else begin
                // The escape closes and the ending byte is decoded as body.
                phase_next = body_phase;
                res0       = make_res(KIND_BYTE, acc[7:0], ERR_BAD_BYTE, '0);
                res1       = body_res;
                res_n      = body_has ? 2'd2 : 2'd1;
            end
        end

        if (res_n == 2'd1) begin
            res0.last = 1'b1;
        end
        if (res_n == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    // Result queue: the head is always entry zero.
    always_comb
    begin
        q_next     = q_reg;
        base       = q_cnt_reg - {1'b0, pop};
        q_cnt_next = base;
        if (pop) begin
            q_next[0] = q_reg[1];
            q_next[1] = q_reg[2];
        end
        if (push && res_n != 2'd0) begin
            q_next[base] = res0;
            q_cnt_next   = base + 2'd1;
            if (res_n == 2'd2) begin
                q_next[base + 2'd1] = res1;
                q_cnt_next          = base + 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            delim_reg    <= DELIM_RESET;
            phase_reg    <= PH_IDLE;
            radix_reg    <= RADIX_DEC;
            cnt_reg      <= 3'd0;
            acc_reg      <= 10'd0;
            esc_pos_reg  <= '0;
            byte_pos_reg <= '0;
            q_cnt_reg    <= 2'd0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                delim_reg <= cfg_data;
            end
            if (push) begin
                phase_reg    <= phase_next;
                radix_reg    <= radix_next;
                cnt_reg      <= cnt_next;
                acc_reg      <= acc_next;
                esc_pos_reg  <= esc_pos_next;
                byte_pos_reg <= byte_pos_next;
            end
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    // A byte taken while no string is open must not queue anything.
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        push && !start_req &&
        (phase_reg == PH_IDLE || phase_reg == PH_DONE || phase_reg == PH_FAIL)
        |=> q_cnt_reg == $past(q_cnt_reg) - {1'b0, $past(pop)})
        else $error("result queued outside an open string");

    // Any error result leaves the decoder failed until the next start.
    a_error_fails: assert property (@(posedge clk) disable iff (!rst_n)
        push && res_n != 2'd0 && res0.kind == KIND_ERROR |=> phase_reg == PH_FAIL)
        else $error("decoder still running after an error");

    // A decoded byte carries neither an error code nor a position.
    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> error_code == ERR_BAD_BYTE && position == '0)
        else $error("decoded byte with stray fields");

    // Exactly the final result of a byte is marked last.
    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        push && res_n == 2'd2 |-> !res0.last && res1.last)
        else $error("last marks the wrong result");

endmodule
